[sv/undecimated_wavelet_line_filter_unit_defines.svh]
// Assertion macros for the wavelet line filter unit.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef UNDECIMATED_WAVELET_LINE_FILTER_UNIT_DEFINES_SVH
`define UNDECIMATED_WAVELET_LINE_FILTER_UNIT_DEFINES_SVH

// Clocked property, off during reset.
`define UWLF_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A stalled beat keeps a signal unchanged in the next cycle.
`define UWLF_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

[sv/uwlf_pkg.sv]
// Shared types and constants of the wavelet line filter unit.
// No dependencies.
package uwlf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int NUM_COEFS  = 16;
	localparam int VAL_W      = 20;
	localparam int POS_W      = 12;
	localparam int FRAC_BITS  = 14;
	localparam int ROUND_BIAS = 8192;
	localparam int VAL_MAX    = 524287;
	localparam int VAL_MIN    = -524288;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int TAPCFG_W   = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_C    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_D    = 3'd4;

	localparam logic [TAPCFG_W-1:0] TAP_COUNT_RST = 5'd2;
	localparam logic [CFG_W-1:0]    COEF_A_RST    = 64'd759246145;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PLAN,
		S_MAC,
		S_DRAIN,
		S_OUT,
		S_NEXT
	} uwlf_state_t;

	typedef struct packed {
		logic accept;
		logic acc_clear;
		logic issue;
		logic load_out;
		logic end_line;
	} uwlf_cmd_t;

	typedef struct packed {
		logic stored;
		logic eol;
		logic pipe_busy;
		logic out_free;
	} uwlf_stat_t;

endpackage

[sv/uwlf_datapath.sv]
// Datapath: configuration registers, line stores, tap MAC pipeline, output register.
// Depends on uwlf_pkg; driven by uwlf_controller.
module uwlf_datapath import uwlf_pkg::*; #(
	parameter int MAX_TAPS  = 16,
	parameter int MAX_BLOCK = 4096,
	localparam int IDX_W = $clog2(MAX_BLOCK),
	localparam int CNT_W = $clog2(MAX_BLOCK + 1),
	localparam int TAP_W = $clog2(MAX_TAPS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       end_of_line,
	input  uwlf_cmd_t                  cmd,
	input  logic [IDX_W-1:0]           fetch_idx,
	input  logic [TAP_W-1:0]           fetch_j,
	input  logic [IDX_W-1:0]           out_idx,
	output uwlf_stat_t                 stat,
	output logic [CNT_W-1:0]           len,
	output logic [TAP_W-1:0]           taps,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VAL_W-1:0]    low_value,
	output logic signed [VAL_W-1:0]    high_value,
	output logic [POS_W-1:0]           position,
	output logic                       final_output,
	output logic                       clipped,
	output logic                       overflow
);

	localparam int SLOT_W = $clog2(MAX_TAPS);
	localparam int HEAD_D = MAX_TAPS - 1;
	localparam int HEAD_W = (HEAD_D > 1) ? $clog2(HEAD_D) : 1;
	localparam int ACC_W  = 34 + TAP_W;

	logic [TAPCFG_W-1:0] tap_count_q;
	logic [CFG_W-1:0]    coef_q [4];
	logic [NUM_COEFS*COEF_W-1:0] coef_all;

	logic signed [SAMPLE_W-1:0] head_q   [HEAD_D];
	logic signed [SAMPLE_W-1:0] window_q [MAX_TAPS];

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  len_q;
	logic              ovf_q;
	logic              eol_q;
	logic              stored_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic [SLOT_W-1:0] last_slot_q;
	logic              full;

	logic [CNT_W-1:0]           lag;
	logic                       in_win;
	logic [SLOT_W-1:0]          lag_s;
	logic [SLOT_W:0]            slot_sum;
	logic [SLOT_W-1:0]          rd_slot;
	logic signed [SAMPLE_W-1:0] x_rd;
	logic [TAP_W-1:0]           k_hi;

	logic                       v_s1, v_s2;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic signed [COEF_W-1:0]   ca_s1, cb_s1;
	logic                       neg_s1;
	logic signed [31:0]         plo_s2;
	logic signed [32:0]         phi_s2;
	logic signed [32:0]         p_hi;

	logic signed [ACC_W-1:0] lo_acc_q, hi_acc_q;
	logic signed [ACC_W-1:0] lo_r, hi_r;
	logic                    clip_lo, clip_hi;
	logic signed [VAL_W-1:0] lo_sat, hi_sat;
	logic                    out_valid_q;

	function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_W-1:0] k);
		logic signed [COEF_W-1:0] c;
		c = '0;
		if (32'(k) < NUM_COEFS)
			c = $signed(coef_all[COEF_W*int'(k) +: COEF_W]);
		return c;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RST;
			coef_q[0]   <= COEF_A_RST;
			coef_q[1]   <= '0;
			coef_q[2]   <= '0;
			coef_q[3]   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAP_COUNT: tap_count_q <= cfg_data[TAPCFG_W-1:0];
				CFG_COEF_A:    coef_q[0]   <= cfg_data;
				CFG_COEF_B:    coef_q[1]   <= cfg_data;
				CFG_COEF_C:    coef_q[2]   <= cfg_data;
				CFG_COEF_D:    coef_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef_all = {coef_q[3], coef_q[2], coef_q[1], coef_q[0]};

	always_comb begin
		if (tap_count_q < 5'd2)
			taps = TAP_W'(2);
		else if (32'(tap_count_q) > MAX_TAPS)
			taps = TAP_W'(MAX_TAPS);
		else
			taps = TAP_W'(tap_count_q);
	end

	// Line bookkeeping
	assign full = (32'(cnt_q) >= MAX_BLOCK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			eol_q       <= 1'b0;
			stored_q    <= 1'b0;
			next_slot_q <= '0;
			last_slot_q <= '0;
		end else if (cmd.accept) begin
			eol_q <= end_of_line;
			if (full) begin
				ovf_q    <= 1'b1;
				len_q    <= CNT_W'(MAX_BLOCK);
				stored_q <= 1'b0;
			end else begin
				cnt_q       <= cnt_q + CNT_W'(1);
				len_q       <= cnt_q + CNT_W'(1);
				stored_q    <= 1'b1;
				last_slot_q <= next_slot_q;
				next_slot_q <= (32'(next_slot_q) == MAX_TAPS - 1) ? '0
				               : next_slot_q + SLOT_W'(1);
			end
		end else if (cmd.end_line) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			next_slot_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !full) begin
			if (32'(cnt_q) < HEAD_D)
				head_q[HEAD_W'(cnt_q)] <= sample;
			window_q[next_slot_q] <= sample;
		end
	end

	// Sample fetch: window slot if still held, else head, else zero
	always_comb begin
		lag      = len_q - CNT_W'(1) - CNT_W'(fetch_idx);
		in_win   = (32'(lag) < MAX_TAPS);
		lag_s    = SLOT_W'(lag);
		slot_sum = (SLOT_W+1)'(last_slot_q) + (SLOT_W+1)'(MAX_TAPS) - (SLOT_W+1)'(lag_s);
		if (32'(slot_sum) >= MAX_TAPS)
			rd_slot = SLOT_W'(slot_sum - (SLOT_W+1)'(MAX_TAPS));
		else
			rd_slot = SLOT_W'(slot_sum);
		if (in_win)
			x_rd = window_q[rd_slot];
		else if (32'(fetch_idx) < HEAD_D)
			x_rd = head_q[HEAD_W'(fetch_idx)];
		else
			x_rd = '0;
		k_hi = taps - TAP_W'(1) - fetch_j;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	assign p_hi = x_s1 * cb_s1;

	always_ff @(posedge clk) begin
		x_s1   <= x_rd;
		ca_s1  <= coef_at(fetch_j);
		cb_s1  <= coef_at(k_hi);
		neg_s1 <= ~k_hi[0];
		plo_s2 <= x_s1 * ca_s1;
		phi_s2 <= neg_s1 ? -p_hi : p_hi;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			lo_acc_q <= '0;
			hi_acc_q <= '0;
		end else if (v_s2) begin
			lo_acc_q <= lo_acc_q + ACC_W'(plo_s2);
			hi_acc_q <= hi_acc_q + ACC_W'(phi_s2);
		end
	end

	// Round half up, floor shift, saturate
	always_comb begin
		lo_r    = (lo_acc_q + ACC_W'(ROUND_BIAS)) >>> FRAC_BITS;
		hi_r    = (hi_acc_q + ACC_W'(ROUND_BIAS)) >>> FRAC_BITS;
		clip_lo = (lo_r > ACC_W'(VAL_MAX)) || (lo_r < ACC_W'(VAL_MIN));
		clip_hi = (hi_r > ACC_W'(VAL_MAX)) || (hi_r < ACC_W'(VAL_MIN));
		if (clip_lo)
			lo_sat = lo_r[ACC_W-1] ? VAL_W'(VAL_MIN) : VAL_W'(VAL_MAX);
		else
			lo_sat = VAL_W'(lo_r);
		if (clip_hi)
			hi_sat = hi_r[ACC_W-1] ? VAL_W'(VAL_MIN) : VAL_W'(VAL_MAX);
		else
			hi_sat = VAL_W'(hi_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			low_value    <= lo_sat;
			high_value   <= hi_sat;
			position     <= POS_W'(out_idx);
			final_output <= (CNT_W'(out_idx) + CNT_W'(1) == len_q);
			clipped      <= clip_lo | clip_hi;
			overflow     <= ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign len            = len_q;
	assign stat.stored    = stored_q;
	assign stat.eol       = eol_q;
	assign stat.pipe_busy = v_s1 | v_s2;
	assign stat.out_free  = !out_valid_q || out_ready;

endmodule

[sv/uwlf_controller.sv]
// Controller: sequences the outputs of each sample and the taps of each output.
// Depends on uwlf_pkg; commands uwlf_datapath.
module uwlf_controller import uwlf_pkg::*; #(
	parameter int MAX_TAPS  = 16,
	parameter int MAX_BLOCK = 4096,
	localparam int IDX_W = $clog2(MAX_BLOCK),
	localparam int CNT_W = $clog2(MAX_BLOCK + 1),
	localparam int TAP_W = $clog2(MAX_TAPS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  uwlf_stat_t       stat,
	input  logic [CNT_W-1:0] len,
	input  logic [TAP_W-1:0] taps,
	output uwlf_cmd_t        cmd,
	output logic [IDX_W-1:0] fetch_idx,
	output logic [TAP_W-1:0] fetch_j,
	output logic [IDX_W-1:0] out_idx
);

	uwlf_state_t state_q, state_d;
	logic [IDX_W-1:0] i_q, m_q, m_next;
	logic [TAP_W-1:0] j_q;
	logic             len_ge_taps, emit_first, has_eol, more, last_tap;
	logic [IDX_W-1:0] first_i, eol_start;

	always_comb begin
		len_ge_taps = (len >= CNT_W'(taps));
		emit_first  = stat.stored && len_ge_taps;
		first_i     = IDX_W'(len - CNT_W'(taps));
		eol_start   = len_ge_taps ? IDX_W'(len - CNT_W'(taps) + CNT_W'(1)) : '0;
		has_eol     = (CNT_W'(eol_start) < len);
		more        = stat.eol && (CNT_W'(i_q) + CNT_W'(1) < len);
		last_tap    = (j_q == taps - TAP_W'(1));
		// wrap around the line, as often as a short line needs
		m_next      = (CNT_W'(m_q) + CNT_W'(1) == len) ? '0 : m_q + IDX_W'(1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_PLAN;
			S_PLAN: begin
				if (emit_first || (stat.eol && has_eol))
					state_d = S_MAC;
				else
					state_d = S_IDLE;
			end
			S_MAC:   if (last_tap) state_d = S_DRAIN;
			S_DRAIN: if (!stat.pipe_busy) state_d = S_OUT;
			S_OUT:   if (stat.out_free) state_d = S_NEXT;
			S_NEXT:  state_d = more ? S_MAC : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_PLAN: begin
				cmd.acc_clear = emit_first || (stat.eol && has_eol);
				cmd.end_line  = !emit_first && stat.eol && !has_eol;
			end
			S_MAC:   cmd.issue    = 1'b1;
			S_OUT:   cmd.load_out = stat.out_free;
			S_NEXT: begin
				cmd.acc_clear = more;
				cmd.end_line  = stat.eol && !more;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			m_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_PLAN: begin
					i_q <= emit_first ? first_i : eol_start;
					m_q <= emit_first ? first_i : eol_start;
					j_q <= '0;
				end
				S_MAC: begin
					j_q <= j_q + TAP_W'(1);
					m_q <= m_next;
				end
				S_NEXT: begin
					i_q <= i_q + IDX_W'(1);
					m_q <= i_q + IDX_W'(1);
					j_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign fetch_idx = m_q;
	assign fetch_j   = j_q;
	assign out_idx   = i_q;

endmodule

[sv/undecimated_wavelet_line_filter_unit.sv]
// A sample is taken and planned, then each output pair that it releases is computed in turn;
// the last sample of a line releases taps pairs (all of them on a line shorter than that).
// Throughput is set by the single shared multiply-accumulate unit, one tap per cycle.
// A finished pair waits in the output register while the next sample is taken.
// Reset clears control and counters and sets configuration to its defaults; line stores are undefined until written.
module undecimated_wavelet_line_filter_unit import uwlf_pkg::*; #(
	parameter int MAX_TAPS  = 16,
	parameter int MAX_BLOCK = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       end_of_line,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VAL_W-1:0]    low_value,
	output logic signed [VAL_W-1:0]    high_value,
	output logic [POS_W-1:0]           position,
	output logic                       final_output,
	output logic                       clipped,
	output logic                       overflow
);

	localparam int IDX_W = $clog2(MAX_BLOCK);
	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int TAP_W = $clog2(MAX_TAPS + 1);

	uwlf_cmd_t        cmd;
	uwlf_stat_t       stat;
	logic [CNT_W-1:0] len;
	logic [TAP_W-1:0] taps;
	logic [IDX_W-1:0] fetch_idx;
	logic [TAP_W-1:0] fetch_j;
	logic [IDX_W-1:0] out_idx;

	uwlf_controller #(
		.MAX_TAPS (MAX_TAPS),
		.MAX_BLOCK(MAX_BLOCK)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.len      (len),
		.taps     (taps),
		.cmd      (cmd),
		.fetch_idx(fetch_idx),
		.fetch_j  (fetch_j),
		.out_idx  (out_idx)
	);

	uwlf_datapath #(
		.MAX_TAPS (MAX_TAPS),
		.MAX_BLOCK(MAX_BLOCK)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample      (sample),
		.end_of_line (end_of_line),
		.cmd         (cmd),
		.fetch_idx   (fetch_idx),
		.fetch_j     (fetch_j),
		.out_idx     (out_idx),
		.stat        (stat),
		.len         (len),
		.taps        (taps),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.low_value   (low_value),
		.high_value  (high_value),
		.position    (position),
		.final_output(final_output),
		.clipped     (clipped),
		.overflow    (overflow)
	);

endmodule

[sv/uwlf_checker.sv]
// Port-level checks of the wavelet line filter unit, bound to the top level.
// Depends on uwlf_pkg and undecimated_wavelet_line_filter_unit_defines.svh.
`include "undecimated_wavelet_line_filter_unit_defines.svh"

module uwlf_checker import uwlf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [VAL_W-1:0] low_value,
	input logic signed [VAL_W-1:0] high_value,
	input logic [POS_W-1:0]        position,
	input logic                    clipped
);

	localparam logic signed [VAL_W-1:0] V_MAX = VAL_W'(VAL_MAX);
	localparam logic signed [VAL_W-1:0] V_MIN = VAL_W'(VAL_MIN);

	`UWLF_ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> out_valid, "output beat dropped while stalled")
	`UWLF_ASSERT_HOLD(a_pos_hold, out_valid, out_ready, position, "position changed while stalled")
	`UWLF_ASSERT_CLK(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "second beat taken before the first was planned")
	`UWLF_ASSERT_CLK(a_clip_flag, (out_valid && low_value != V_MAX && low_value != V_MIN && high_value != V_MAX && high_value != V_MIN) |-> !clipped, "clip flag set on unsaturated values")

endmodule

bind undecimated_wavelet_line_filter_unit uwlf_checker u_uwlf_checker (.*);
